// ----- design/line_column_substring_matcher_core_defines.svh -----
// Assertion macros shared by the matcher RTL.
`ifndef LINE_COLUMN_SUBSTRING_MATCHER_CORE_DEFINES_SVH
`define LINE_COLUMN_SUBSTRING_MATCHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, switched off while reset is high
`define LCSM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lcsm check failed");

// Clocked check that also holds through reset
`define LCSM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("lcsm check failed");

`else

`define LCSM_ASSERT(label, clk, rst, prop)
`define LCSM_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- design/lcsm_pkg.sv -----
// Shared constants, types and helpers for the line/column substring matcher.
package lcsm_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W       = 5;
  localparam int CHAR_W      = 8;
  localparam int LINE_W      = 24;
  localparam int COL_W       = 16;
  localparam int COUNT_W     = 24;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CHAR_W-1:0]  NEWLINE   = 8'd10;
  localparam logic [LINE_W-1:0]  LINE_MAX  = {LINE_W{1'b1}};
  localparam logic [COL_W-1:0]   COL_MAX   = {COL_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Input command codes
  localparam logic CMD_TEXT  = 1'b0;
  localparam logic CMD_TOTAL = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 2'd2;

  // Per-cell control, same for every cell but the enable mask
  typedef struct packed {
    logic shift;   // take the neighbour's byte this cycle
    logic active;  // cell falls inside the pattern length
  } cell_ctrl_t;

  // Result beat payload, line number in the low bits
  typedef struct packed {
    logic [COUNT_W-1:0] match_count;
    logic [COL_W-1:0]   column_number;
    logic [LINE_W-1:0]  line_number;
  } result_t;

  // Pick pattern byte idx out of the two 64-bit pattern registers
  function automatic logic [CHAR_W-1:0] pattern_byte(input logic [127:0] pat,
                                                      input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] b;
    b = pat[idx*CHAR_W +: CHAR_W];
    return b;
  endfunction

endpackage

// ----- design/lcsm_cell.sv -----
// One cell of the search chain: holds one recent byte and its compare flag.
module lcsm_cell (
  input  logic                        clk,
  input  lcsm_pkg::cell_ctrl_t        ctrl,
  input  logic [lcsm_pkg::CHAR_W-1:0] char_in,
  input  logic [lcsm_pkg::CHAR_W-1:0] expected,
  output logic [lcsm_pkg::CHAR_W-1:0] char_q,
  output logic                        eq
);

  // byte moves one cell down the chain; compare the incoming byte on the way in
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      char_q <= char_in;
      eq     <= !ctrl.active || (char_in == expected);
    end
  end

endmodule

// ----- design/line_column_substring_matcher_core.sv -----
// Top level of the line/column substring matcher: cell chain, counters, result register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  text in  | s_tvalid / s_tready        | s_tdata = character, s_tuser = command
//  result   | m_tvalid / m_tready        | m_tdata = line, column, count; m_tuser = is_total
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data (cfg_ready always high)
//
// One byte per cycle while m_tready does not stall; a beat is registered in the compare
// stage (cell chain compare), then the result register (AND over the cells, count update).
// rst is synchronous; it clears the pattern, the column and match counters and both stage
// valids, and sets the line counter to 1. A stall on m_tready holds the result register and,
// through it, the compare stage; s_tready stays high while either stage can still move.
`include "line_column_substring_matcher_core_defines.svh"

module line_column_substring_matcher_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] character
  input  logic                           s_tuser,   // [0] command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [63:0]                    m_tdata,   // [23:0] line, [39:24] column, [63:40] count
  output logic                           m_tuser,   // [0] is_total
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lcsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);

  localparam int N = lcsm_pkg::PATTERN_MAX;

  // configuration registers
  logic [63:0]                  pattern_lo;
  logic [63:0]                  pattern_hi;
  logic [lcsm_pkg::LEN_W-1:0]   pattern_len;
  logic [lcsm_pkg::LEN_W-1:0]   eff_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_lo  <= '0;
      pattern_hi  <= '0;
      pattern_len <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lcsm_pkg::REG_PATTERN_LO:  pattern_lo  <= cfg_data;
        lcsm_pkg::REG_PATTERN_HI:  pattern_hi  <= cfg_data;
        lcsm_pkg::REG_PATTERN_LEN: pattern_len <= cfg_data[lcsm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp length to the chain depth
  assign eff_len = (pattern_len > lcsm_pkg::LEN_W'(N)) ? lcsm_pkg::LEN_W'(N) : pattern_len;

  // pipeline handshake
  logic v1;
  logic ready1, ready2, accept;

  assign ready2   = !m_tvalid || m_tready;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;
  assign accept   = s_tvalid && ready1;

  // input decode
  logic is_char;
  assign is_char = (s_tuser == lcsm_pkg::CMD_TEXT) && (s_tdata != lcsm_pkg::NEWLINE);

  // cell chain
  lcsm_pkg::cell_ctrl_t        ctrl [N];
  logic [lcsm_pkg::CHAR_W-1:0] chain_in [N];
  logic [lcsm_pkg::CHAR_W-1:0] chain_q  [N];
  logic [lcsm_pkg::CHAR_W-1:0] expected [N];
  logic [N-1:0]                eq;

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [lcsm_pkg::LEN_W-1:0] pidx;

    // cell k holds the byte k places back; it meets pattern byte len-1-k
    assign pidx           = eff_len - lcsm_pkg::LEN_W'(1) - lcsm_pkg::LEN_W'(k);
    assign expected[k]    = lcsm_pkg::pattern_byte({pattern_hi, pattern_lo},
                                                   pidx[lcsm_pkg::IDX_W-1:0]);
    assign ctrl[k].shift  = accept && is_char;
    assign ctrl[k].active = lcsm_pkg::LEN_W'(k) < eff_len;

    if (k == 0) begin : g_head
      assign chain_in[k] = s_tdata;
    end else begin : g_body
      assign chain_in[k] = chain_q[k-1];
    end

    lcsm_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[k]),
      .char_in  (chain_in[k]),
      .expected (expected[k]),
      .char_q   (chain_q[k]),
      .eq       (eq[k])
    );
  end

  // line and column counters
  logic [lcsm_pkg::COL_W-1:0]  chars_in_line, chars_in_line_next, col_inc;
  logic [lcsm_pkg::LINE_W-1:0] current_line, current_line_next;

  assign col_inc = (chars_in_line < lcsm_pkg::COL_MAX) ?
                   chars_in_line + lcsm_pkg::COL_W'(1) : chars_in_line;

  always_comb begin
    chars_in_line_next = chars_in_line;
    current_line_next  = current_line;
    if (accept && s_tuser == lcsm_pkg::CMD_TEXT) begin
      if (s_tdata == lcsm_pkg::NEWLINE) begin
        chars_in_line_next = '0;
        if (current_line < lcsm_pkg::LINE_MAX)
          current_line_next = current_line + lcsm_pkg::LINE_W'(1);
      end else begin
        chars_in_line_next = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_in_line <= '0;
      current_line  <= lcsm_pkg::LINE_W'(1);
    end else begin
      chars_in_line <= chars_in_line_next;
      current_line  <= current_line_next;
    end
  end

  // compare stage registers
  logic                        cmd1, char1, len_ok1;
  logic [lcsm_pkg::LINE_W-1:0] line1;
  logic [lcsm_pkg::COL_W-1:0]  col1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd1    <= s_tuser;
      char1   <= is_char;
      line1   <= current_line;
      col1    <= col_inc - lcsm_pkg::COL_W'(eff_len) + lcsm_pkg::COL_W'(1);
      len_ok1 <= (eff_len != '0) && (col_inc >= lcsm_pkg::COL_W'(eff_len));
    end
  end

  // match decision and running count
  logic                         hit;
  logic [lcsm_pkg::COUNT_W-1:0] matches_found, matches_found_next;
  lcsm_pkg::result_t            result;

  assign hit = v1 && (cmd1 == lcsm_pkg::CMD_TEXT) && char1 && len_ok1 && (&eq);

  always_comb begin
    matches_found_next = matches_found;
    if (ready2 && hit && matches_found < lcsm_pkg::COUNT_MAX)
      matches_found_next = matches_found + lcsm_pkg::COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matches_found <= '0;
    end else begin
      matches_found <= matches_found_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready2) begin
      m_tvalid <= v1 && ((cmd1 == lcsm_pkg::CMD_TOTAL) || hit);
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      if (cmd1 == lcsm_pkg::CMD_TOTAL) begin
        m_tuser <= 1'b1;
        result  <= '{match_count: matches_found, column_number: '0, line_number: '0};
      end else begin
        m_tuser <= 1'b0;
        result  <= '{match_count: matches_found_next, column_number: col1,
                     line_number: line1};
      end
    end
  end

  assign m_tdata = result;

  // checks
  `LCSM_ASSERT(a_total_zero_pos, clk, rst, m_tvalid && m_tuser |-> m_tdata[39:0] == 40'd0)

  `LCSM_ASSERT(a_match_pos_set, clk, rst,
               m_tvalid && !m_tuser |-> m_tdata[23:0] != 24'd0 && m_tdata[39:24] != 16'd0)

  `LCSM_ASSERT(a_count_monotonic, clk, rst,
               !$past(rst) |-> matches_found >= $past(matches_found))

  `LCSM_ASSERT(a_count_step_reported, clk, rst,
               !$past(rst) && matches_found != $past(matches_found) |->
               m_tvalid && !m_tuser && m_tdata[63:40] == matches_found)

endmodule
